@@ rtl/core/ced_pkg.sv @@
// Shared types and constants for the escape sequence decoder.
`timescale 1ns / 1ps

package ced_pkg;

	// Depth of the queue between the decoder front and the output back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One decoded input character: one or two bytes waiting for output.
	typedef struct packed {
		logic       two;
		logic [7:0] b0;
		logic [7:0] b1;
	} ced_entry_t;

endpackage

@@ rtl/core/ced_front.sv @@
// Decoder front: accepts characters, tracks escape state and queues the decoded bytes.
`timescale 1ns / 1ps

module ced_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          char_in,
	input  logic                string_end,
	output logic                push_valid,
	input  logic                push_ready,
	output ced_pkg::ced_entry_t push_entry
);

	// Number mode codes; the spare code behaves as no number.
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_OCT  = 2'd1;
	localparam logic [1:0] MODE_HEX  = 2'd2;

	localparam logic [1:0] OCT_DIGITS = 2'd3;
	localparam logic [1:0] HEX_DIGITS = 2'd2;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_X      = 8'h78;

	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_HT = 8'h09;
	localparam logic [7:0] CTL_VT = 8'h0B;

	logic       esc_q;
	logic [1:0] mode_q;
	logic [1:0] cnt_q;
	logic [8:0] acc_q;

	logic       esc_d;
	logic [1:0] mode_d;
	logic [1:0] cnt_d;
	logic [8:0] acc_d;

	logic [1:0] nres;
	logic [7:0] r0;
	logic [7:0] r1;
	logic       consumed;
	logic       do_close;
	logic       is_oct;
	logic       is_hex;
	logic [3:0] hex_val;
	logic       accept;

	// Digit classification of the incoming character.
	always_comb begin
		is_oct  = char_in inside {[8'h30:8'h37]};
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (char_in inside {[8'h30:8'h39]}) begin
			hex_val = char_in[3:0];
		end else if (char_in inside {[8'h61:8'h66]} || char_in inside {[8'h41:8'h46]}) begin
			hex_val = 4'(char_in[2:0] + 3'd1) + 4'd8;
		end else begin
			is_hex = 1'b0;
		end
	end

	// Next state and up to two decoded bytes for the current character.
	always_comb begin
		esc_d    = esc_q;
		mode_d   = mode_q;
		cnt_d    = cnt_q;
		acc_d    = acc_q;
		nres     = 2'd0;
		r0       = 8'd0;
		r1       = 8'd0;
		consumed = 1'b0;
		do_close = 1'b0;

		// An open number either takes the character as a digit or is closed.
		case (mode_q)
			MODE_OCT: begin
				if (is_oct) begin
					acc_d    = {acc_q[5:0], char_in[2:0]};
					cnt_d    = cnt_q + 2'd1;
					consumed = 1'b1;
					do_close = (cnt_d == OCT_DIGITS);
				end else begin
					do_close = 1'b1;
				end
			end
			MODE_HEX: begin
				if (is_hex) begin
					acc_d    = {acc_q[4:0], hex_val};
					cnt_d    = cnt_q + 2'd1;
					consumed = 1'b1;
					do_close = (cnt_d == HEX_DIGITS);
				end else begin
					do_close = 1'b1;
				end
			end
			MODE_NONE: begin
			end
			default: begin
				mode_d = MODE_NONE;
				cnt_d  = 2'd0;
				acc_d  = 9'd0;
			end
		endcase

		if (do_close) begin
			if (mode_q == MODE_OCT || (mode_q == MODE_HEX && cnt_d != 2'd0)) begin
				r0   = acc_d[7:0];
				nres = 2'd1;
			end
			mode_d = MODE_NONE;
			cnt_d  = 2'd0;
			acc_d  = 9'd0;
		end

		// Ordinary handling of a character that no number took.
		if (!consumed) begin
			if (esc_q) begin
				esc_d = 1'b0;
				case (char_in)
					CH_B:    begin r1 = CTL_BS; end
					CH_F:    begin r1 = CTL_FF; end
					CH_N:    begin r1 = CTL_LF; end
					CH_R:    begin r1 = CTL_CR; end
					CH_T:    begin r1 = CTL_HT; end
					CH_V:    begin r1 = CTL_VT; end
					default: begin r1 = char_in; end
				endcase
				if (char_in == CH_X) begin
					mode_d = MODE_HEX;
					cnt_d  = 2'd0;
					acc_d  = 9'd0;
				end else if (is_oct) begin
					mode_d = MODE_OCT;
					cnt_d  = 2'd1;
					acc_d  = {6'd0, char_in[2:0]};
				end else if (nres == 2'd0) begin
					r0   = r1;
					r1   = 8'd0;
					nres = 2'd1;
				end else begin
					nres = 2'd2;
				end
			end else if (char_in == CH_BSLASH) begin
				esc_d = 1'b1;
			end else if (nres == 2'd0) begin
				r0   = char_in;
				nres = 2'd1;
			end else begin
				r1   = char_in;
				nres = 2'd2;
			end
		end

		// End of string closes whatever is still open.
		if (string_end) begin
			if (mode_d != MODE_NONE) begin
				if (mode_d == MODE_OCT || (mode_d == MODE_HEX && cnt_d != 2'd0)) begin
					if (nres == 2'd0) begin
						r0   = acc_d[7:0];
						nres = 2'd1;
					end else if (nres == 2'd1) begin
						r1   = acc_d[7:0];
						nres = 2'd2;
					end
				end
				mode_d = MODE_NONE;
				cnt_d  = 2'd0;
				acc_d  = 9'd0;
			end
			esc_d = 1'b0;
		end
	end

	// The queue's free space alone gates intake.
	assign in_ready   = push_ready;
	assign accept     = in_valid && push_ready;
	assign push_valid = in_valid && (nres != 2'd0);

	always_comb begin
		push_entry.two = (nres == 2'd2);
		push_entry.b0  = r0;
		push_entry.b1  = r1;
	end

	// Escape and number state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			mode_q <= MODE_NONE;
			cnt_q  <= 2'd0;
			acc_q  <= 9'd0;
		end else if (accept) begin
			esc_q  <= esc_d;
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
		end
	end

endmodule

@@ rtl/core/ced_queue.sv @@
// Short queue of decoded entries between the decoder front and the output back.
`timescale 1ns / 1ps

module ced_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  ced_pkg::ced_entry_t push_entry,
	output logic                pop_valid,
	input  logic                pop_ready,
	output ced_pkg::ced_entry_t pop_entry
);

	ced_pkg::ced_entry_t              mem_q [ced_pkg::QUEUE_DEPTH];
	logic [ced_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [ced_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [ced_pkg::QCNT_W-1:0]       count_q;
	logic                             do_push;
	logic                             do_pop;

	assign push_ready = (count_q != ced_pkg::QCNT_W'(ced_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers wrap naturally since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

@@ rtl/core/ced_back.sv @@
// Output back: splits queued entries into single bytes behind an output register.
`timescale 1ns / 1ps

module ced_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  ced_pkg::ced_entry_t pop_entry,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          byte_out,
	output logic                run_last
);

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       sel_q;
	logic       load;
	logic       first_of_two;

	// The output register takes a new byte when empty or being drained.
	assign load         = !out_valid_q || out_ready;
	assign first_of_two = pop_entry.two && !sel_q;
	assign pop_ready    = load && !first_of_two;

	assign out_valid = out_valid_q;
	assign byte_out  = byte_q;
	assign run_last  = last_q;

	// Control: output valid and which byte of a two-byte entry is next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else if (load) begin
			out_valid_q <= pop_valid;
			if (pop_valid) begin
				sel_q <= first_of_two;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			byte_q <= sel_q ? pop_entry.b1 : pop_entry.b0;
			last_q <= !first_of_two;
		end
	end

endmodule

@@ rtl/core/c_escape_sequence_decoder.sv @@
// Top level of the C escape sequence decoder.
//
//   Channel  Signals                          Direction  Transfer when
//   input    char_in, string_end              in         in_valid && in_ready
//   output   byte_out, run_last               out        out_valid && out_ready
//
// One character is taken per cycle while the queue has room; the front decodes it in that cycle.
// A character gives zero, one or two bytes; the output register sends one
// byte per cycle while out_ready is high, so a two-byte character leaves as two bytes in turn.
// A byte passes from its character's transfer into the queue and then into the output register,
// and it can leave once it is in the output register.
// A four-entry queue absorbs output stalls; intake stops only when it is full.
// Reset clears the escape state, empties the queue and clears the output valid.
`timescale 1ns / 1ps

module c_escape_sequence_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       string_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_out,
	output logic       run_last
);

	logic                push_valid;
	logic                push_ready;
	ced_pkg::ced_entry_t push_entry;
	logic                pop_valid;
	logic                pop_ready;
	ced_pkg::ced_entry_t pop_entry;

	ced_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_in    (char_in),
		.string_end (string_end),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	ced_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	ced_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.byte_out  (byte_out),
		.run_last  (run_last)
	);

endmodule

@@ rtl/core/ced_checker.sv @@
// Port-level checks for the C escape sequence decoder, bound to the top level.
`timescale 1ns / 1ps

module ced_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] byte_out,
	input logic       run_last
);

	// A stalled output keeps its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(run_last))
		else $error("output changed while stalled");

	// The second byte of a character follows its first without a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("second byte of a character did not follow");

	// A byte that appears on an idle output comes from an input transfer through the queue and the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output appeared without a matching input transfer");

	// Intake stops only while the output holds a byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with an empty output");

endmodule

bind c_escape_sequence_decoder ced_checker u_ced_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.byte_out  (byte_out),
	.run_last  (run_last)
);
